@@ src/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor command parser package
// Shared types, character codes and action codes of the motor command parser.
// ----------------------------------------------------------------------------
package mcp_pkg;

  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [2:0] ACT_FORWARD  = 3'd0;
  localparam logic [2:0] ACT_BACKWARD = 3'd1;
  localparam logic [2:0] ACT_LEFT     = 3'd2;
  localparam logic [2:0] ACT_RIGHT    = 3'd3;
  localparam logic [2:0] ACT_STOP     = 3'd4;
  localparam logic [2:0] ACT_NONE     = 3'd7;

  localparam logic [1:0] EVENT_NONE    = 2'd0;
  localparam logic [1:0] EVENT_APPEAR  = 2'd1;
  localparam logic [1:0] EVENT_CLEAR   = 2'd2;

  localparam logic [6:0]  SPEED_MAX    = 7'd99;
  localparam logic [15:0] RANGE_MIN    = 16'd20;
  localparam logic [15:0] RANGE_MAX    = 16'd2000;
  localparam logic [7:0]  STATUS_OK    = 8'd0;
  localparam logic [7:0]  STATUS_SIGMA = 8'd1;
  localparam logic [10:0] BRAKE_RESET  = 11'd200;

  typedef enum logic [1:0] {
    PHASE_DIR = 2'd0,
    PHASE_D1  = 2'd1,
    PHASE_D2  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       command_issued;
    logic       frame_accepted;
    logic [2:0] action;
    logic [6:0] speed;
    logic       obstacle;
    logic [1:0] obstacle_event;
  } result_t;

  function automatic logic [2:0] letter_code(input logic [7:0] b);
    case (b)
      CHAR_F:  return ACT_FORWARD;
      CHAR_B:  return ACT_BACKWARD;
      CHAR_L:  return ACT_LEFT;
      CHAR_R:  return ACT_RIGHT;
      CHAR_S:  return ACT_STOP;
      default: return ACT_NONE;
    endcase
  endfunction

endpackage

@@ src/mcp_core.sv @@
// ----------------------------------------------------------------------------
// Motor command parser core
// Frame parser state, obstacle flag and the result of one transaction.
// ----------------------------------------------------------------------------
module mcp_core
  import mcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] distance_mm,
  input  logic [7:0]  sensor_status,
  input  logic [10:0] brake_distance,
  output result_t     res
);

  phase_t     parse_phase, parse_phase_next;
  logic [2:0] held_direction, held_direction_next;
  logic [3:0] held_tens, held_tens_next;
  logic       obstacle_flag, obstacle_flag_next;

  logic [2:0] code;
  logic       is_digit;
  logic [3:0] units;
  logic [6:0] tens_x10;
  logic [7:0] speed_sum;
  logic [6:0] speed_val;
  logic       reading_valid;
  logic       near;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PHASE_DIR;
      held_direction <= ACT_FORWARD;
      held_tens      <= 4'd0;
      obstacle_flag  <= 1'b0;
    end else if (accept) begin
      parse_phase    <= parse_phase_next;
      held_direction <= held_direction_next;
      held_tens      <= held_tens_next;
      obstacle_flag  <= obstacle_flag_next;
    end
  end

  always_comb begin
    code          = letter_code(rx_byte);
    is_digit      = rx_byte inside {[CHAR_0:CHAR_9]};
    units         = rx_byte[3:0];
    tens_x10      = {held_tens, 3'b000} + 7'({held_tens, 1'b0});
    speed_sum     = {1'b0, tens_x10} + 8'(units);
    speed_val     = (speed_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : speed_sum[6:0];
    reading_valid = (sensor_status == STATUS_OK || sensor_status == STATUS_SIGMA) &&
                    distance_mm > RANGE_MIN && distance_mm < RANGE_MAX;
    near          = distance_mm < {5'b0, brake_distance};

    parse_phase_next    = parse_phase;
    held_direction_next = held_direction;
    held_tens_next      = held_tens;
    obstacle_flag_next  = obstacle_flag;
    res                 = '0;

    if (!operation) begin
      case (parse_phase)
        PHASE_DIR: begin
          if (code != ACT_NONE) begin
            held_direction_next = code;
            parse_phase_next    = PHASE_D1;
          end
        end
        PHASE_D1: begin
          if (is_digit) begin
            held_tens_next   = units;
            parse_phase_next = PHASE_D2;
          end else if (code != ACT_NONE) begin
            held_direction_next = code;
            parse_phase_next    = PHASE_D1;
          end else begin
            parse_phase_next = PHASE_DIR;
          end
        end
        PHASE_D2: begin
          if (is_digit && !(held_direction == ACT_FORWARD && obstacle_flag)) begin
            res.command_issued = 1'b1;
            res.frame_accepted = 1'b1;
            res.action         = held_direction;
            res.speed          = (held_direction == ACT_STOP) ? 7'd0 : speed_val;
          end
          parse_phase_next = PHASE_DIR;
        end
        default: begin
          parse_phase_next = PHASE_DIR;
        end
      endcase
    end else if (reading_valid) begin
      if (near) begin
        if (!obstacle_flag) begin
          obstacle_flag_next = 1'b1;
          res.command_issued = 1'b1;
          res.action         = ACT_STOP;
          res.obstacle_event = EVENT_APPEAR;
        end
      end else if (obstacle_flag) begin
        obstacle_flag_next = 1'b0;
        res.obstacle_event = EVENT_CLEAR;
      end
    end

    res.obstacle = obstacle_flag_next;
  end

endmodule

@@ src/motor_command_parser_with_obstacle_lock.sv @@
// ----------------------------------------------------------------------------
// Motor command parser with obstacle lock
// Parses three-byte motor frames and locks out forward motion near obstacles.
// ----------------------------------------------------------------------------
// Each input transaction gives exactly one result transaction. The block takes
// one transaction per clock cycle while in_stall is low; its result is captured
// at the accepting edge in the output register, or in the skid register when the
// output register holds a result that is not taken. A two-entry output buffer
// (output register plus skid register) lets input continue while a result waits,
// and in_stall rises only when the skid register is occupied. The brake distance
// register may be written at any time the block is idle and cfg_ready is always high.
module motor_command_parser_with_obstacle_lock
  import mcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] distance_mm,
  input  logic [7:0]  sensor_status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        command_issued,
  output logic        frame_accepted,
  output logic [2:0]  action,
  output logic [6:0]  speed,
  output logic        obstacle,
  output logic [1:0]  obstacle_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  logic [10:0] brake_distance;
  logic        accept;
  logic        take;
  result_t     res;
  result_t     out_q;
  result_t     skid_q;
  logic        out_full;
  logic        skid_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign accept    = in_valid && !in_stall;
  assign take      = out_full && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_distance <= BRAKE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      brake_distance <= cfg_data;
    end
  end

  mcp_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .distance_mm    (distance_mm),
    .sensor_status  (sensor_status),
    .brake_distance (brake_distance),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || take) begin
      if (skid_full) begin
        out_q     <= skid_q;
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else if (accept) begin
        out_q    <= res;
        out_full <= 1'b1;
      end else begin
        out_full <= 1'b0;
      end
    end else if (accept) begin
      skid_q    <= res;
      skid_full <= 1'b1;
    end
  end

  assign out_valid      = out_full;
  assign command_issued = out_q.command_issued;
  assign frame_accepted = out_q.frame_accepted;
  assign action         = out_q.action;
  assign speed          = out_q.speed;
  assign obstacle       = out_q.obstacle;
  assign obstacle_event = out_q.obstacle_event;

endmodule

@@ src/mcp_checker.sv @@
// ----------------------------------------------------------------------------
// Motor command parser checker
// Port-level properties of the motor command parser, bound to the top level.
// ----------------------------------------------------------------------------
module mcp_checker
  import mcp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        command_issued,
  input logic        frame_accepted,
  input logic [2:0]  action,
  input logic [6:0]  speed,
  input logic        obstacle,
  input logic [1:0]  obstacle_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command_issued) &&
      $stable(frame_accepted) && $stable(action) && $stable(speed) &&
      $stable(obstacle) && $stable(obstacle_event))
    else $error("Stalled result transaction changed.");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_issued |-> action == 3'd0 && speed == 7'd0 && !frame_accepted)
    else $error("Fields set without an issued command.");

  a_appear_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle_event == EVENT_APPEAR |->
      obstacle && command_issued && !frame_accepted && action == ACT_STOP && speed == 7'd0)
    else $error("Obstacle appearance without a stop command.");

  a_clear_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && obstacle_event == EVENT_CLEAR |-> !obstacle && !command_issued)
    else $error("Obstacle clearance inconsistent with flag.");

  a_no_forward_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_accepted && obstacle |-> action != ACT_FORWARD)
    else $error("Forward frame accepted while obstacle flagged.");

endmodule

bind motor_command_parser_with_obstacle_lock mcp_checker u_mcp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .command_issued (command_issued),
  .frame_accepted (frame_accepted),
  .action         (action),
  .speed          (speed),
  .obstacle       (obstacle),
  .obstacle_event (obstacle_event)
);

@@ test/tb_motor_command_parser_with_obstacle_lock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command parser with obstacle lock testbench
// Feeds command bytes and range readings through the valid/stall input, with
// random gaps and output back-pressure, and checks every result transaction
// against a cycle-free prediction of the parser and obstacle flag held in a
// scoreboard. The brake distance is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_motor_command_parser_with_obstacle_lock;
  import mcp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;

  class motor_scoreboard;
    logic [10:0] brake_mm;
    phase_t      phase;
    logic [2:0]  held_dir;
    logic [3:0]  held_tens;
    logic        blocked;
    result_t     expected_results[$];
    int          mismatches;
    int          checked;
    int          bytes_seen;
    int          readings_seen;
    int          commands_seen;
    int          refusals_seen;
    int          events_seen;

    function new();
      brake_mm      = BRAKE_RESET;
      phase         = PHASE_DIR;
      held_dir      = ACT_FORWARD;
      held_tens     = '0;
      blocked       = 1'b0;
      mismatches    = 0;
      checked       = 0;
      bytes_seen    = 0;
      readings_seen = 0;
      commands_seen = 0;
      refusals_seen = 0;
      events_seen   = 0;
    endfunction

    function logic [2:0] direction_of(logic [7:0] b);
      if (b == CHAR_F) return ACT_FORWARD;
      if (b == CHAR_B) return ACT_BACKWARD;
      if (b == CHAR_L) return ACT_LEFT;
      if (b == CHAR_R) return ACT_RIGHT;
      if (b == CHAR_S) return ACT_STOP;
      return ACT_NONE;
    endfunction

    function void set_brake(logic [10:0] value);
      brake_mm = value;
    endfunction

    function void take_input(logic op, logic [7:0] b, logic [15:0] d, logic [7:0] s);
      result_t    r;
      logic [2:0] code;
      logic       digit;
      int         total;
      r = '0;
      if (op == 1'b0) begin
        bytes_seen++;
        code  = direction_of(b);
        digit = (b >= CHAR_0) && (b <= CHAR_9);
        case (phase)
          PHASE_DIR: begin
            if (code != ACT_NONE) begin
              held_dir = code;
              phase    = PHASE_D1;
            end
          end
          PHASE_D1: begin
            if (digit) begin
              held_tens = 4'(int'(b) - int'(CHAR_0));
              phase     = PHASE_D2;
            end else if (code != ACT_NONE) begin
              held_dir = code;
            end else begin
              phase = PHASE_DIR;
            end
          end
          PHASE_D2: begin
            if (digit) begin
              total = int'(held_tens) * 10 + (int'(b) - int'(CHAR_0));
              if (total > int'(SPEED_MAX)) total = int'(SPEED_MAX);
              if (held_dir == ACT_FORWARD && blocked) begin
                refusals_seen++;
              end else begin
                r.command_issued = 1'b1;
                r.frame_accepted = 1'b1;
                r.action         = held_dir;
                r.speed          = (held_dir == ACT_STOP) ? 7'd0 : 7'(total);
              end
            end
            phase = PHASE_DIR;
          end
          default: phase = PHASE_DIR;
        endcase
      end else begin
        readings_seen++;
        if ((s == STATUS_OK || s == STATUS_SIGMA) &&
            d > RANGE_MIN && d < RANGE_MAX) begin
          if (d < {5'd0, brake_mm}) begin
            if (!blocked) begin
              blocked          = 1'b1;
              r.command_issued = 1'b1;
              r.action         = ACT_STOP;
              r.speed          = 7'd0;
              r.obstacle_event = EVENT_APPEAR;
            end
          end else if (blocked) begin
            blocked          = 1'b0;
            r.obstacle_event = EVENT_CLEAR;
          end
        end
      end
      r.obstacle = blocked;
      if (r.command_issued) commands_seen++;
      if (r.obstacle_event != EVENT_NONE) events_seen++;
      expected_results.push_back(r);
    endfunction

    function void check_output(result_t got);
      result_t exp;
      logic    bad;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"Unexpected result %0d: issued=%0d accepted=%0d action=%0d",
                    " speed=%0d obstacle=%0d event=%0d"},
                   checked, got.command_issued, got.frame_accepted, got.action, got.speed,
                   got.obstacle, got.obstacle_event);
        return;
      end
      exp = expected_results.pop_front();
      bad = (got.command_issued !== exp.command_issued) ||
            (got.frame_accepted !== exp.frame_accepted) ||
            (got.action !== exp.action) ||
            (got.speed !== exp.speed) ||
            (got.obstacle !== exp.obstacle) ||
            (got.obstacle_event !== exp.obstacle_event);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display({"Result %0d expected: issued=%0d accepted=%0d action=%0d",
                    " speed=%0d obstacle=%0d event=%0d"},
                   checked, exp.command_issued, exp.frame_accepted, exp.action, exp.speed,
                   exp.obstacle, exp.obstacle_event);
          $display({"Result %0d actual:   issued=%0d accepted=%0d action=%0d",
                    " speed=%0d obstacle=%0d event=%0d"},
                   checked, got.command_issued, got.frame_accepted, got.action, got.speed,
                   got.obstacle, got.obstacle_event);
        end
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        operation     = 1'b0;
  logic [7:0]  rx_byte       = '0;
  logic [15:0] distance_mm   = '0;
  logic [7:0]  sensor_status = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        command_issued;
  logic        frame_accepted;
  logic [2:0]  action;
  logic [6:0]  speed;
  logic        obstacle;
  logic [1:0]  obstacle_event;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data      = '0;

  motor_scoreboard sb;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int stuck_cycles = 0;
  int settings_used = 0;

  motor_command_parser_with_obstacle_lock u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .distance_mm    (distance_mm),
    .sensor_status  (sensor_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command_issued (command_issued),
    .frame_accepted (frame_accepted),
    .action         (action),
    .speed          (speed),
    .obstacle       (obstacle),
    .obstacle_event (obstacle_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
  end

  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sb.take_input(operation, rx_byte, distance_mm, sensor_status);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_output({command_issued, frame_accepted, action, speed, obstacle,
                         obstacle_event});
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        sb.set_brake(cfg_data);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", sb.expected_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b, input logic [15:0] d,
                           input logic [7:0] s);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    rx_byte       <= b;
    distance_mm   <= d;
    sensor_status <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_reading(input logic [15:0] d, input logic [7:0] s);
    send_item(1'b1, 8'($urandom_range(0, 255)), d, s);
  endtask

  task automatic send_frame(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    send_byte(a);
    send_byte(b);
    send_byte(c);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_brake(input logic [10:0] value);
    wait_until_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] any_letter();
    case ($urandom_range(0, 4))
      0: return CHAR_F;
      1: return CHAR_B;
      2: return CHAR_L;
      3: return CHAR_R;
      default: return CHAR_S;
    endcase
  endfunction

  task automatic random_traffic(input int count);
    int         done;
    int         pick;
    int         range_mm;
    logic [7:0] a;
    logic [7:0] t;
    logic [7:0] u;
    logic [7:0] s;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        a = any_letter();
        t = CHAR_0 + 8'($urandom_range(0, 9));
        u = CHAR_0 + 8'($urandom_range(0, 9));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0: a = 8'($urandom_range(0, 255));
            1: t = 8'($urandom_range(0, 255));
            default: u = 8'($urandom_range(0, 255));
          endcase
        end
        send_frame(a, t, u);
        done += 3;
      end else if (pick < 85) begin
        case ($urandom_range(0, 5))
          0: range_mm = $urandom_range(0, 65535);
          1, 2: range_mm = $urandom_range(21, 1999);
          3, 4: range_mm = int'(sb.brake_mm) + $urandom_range(0, 6) - 3;
          default: begin
            case ($urandom_range(0, 3))
              0: range_mm = 20;
              1: range_mm = 21;
              2: range_mm = 1999;
              default: range_mm = 2000;
            endcase
          end
        endcase
        s = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
        send_reading(16'(range_mm), s);
        done++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        done++;
      end
    end
  endtask

  initial begin
    sb = new();
    send_gap_pct = 15;
    recv_gap_pct = 48;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions at the reset brake distance.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(CHAR_F, CHAR_0 + 8'd1, CHAR_0 + 8'd2);
    send_frame(CHAR_B, CHAR_9, CHAR_9);
    send_frame(CHAR_S, CHAR_0 + 8'd7, CHAR_0 + 8'd3);
    send_byte(CHAR_L);
    send_byte(8'h3F);
    send_frame(CHAR_R, CHAR_B, CHAR_0 + 8'd4);
    send_byte(CHAR_0 + 8'd5);
    send_frame(CHAR_L, CHAR_0 + 8'd3, CHAR_F);
    send_frame(CHAR_R, CHAR_0, CHAR_0);
    send_reading(16'd100, STATUS_OK);
    send_reading(16'd50, STATUS_SIGMA);
    send_frame(CHAR_F, CHAR_0 + 8'd1, CHAR_0 + 8'd2);
    send_reading(16'd150, 8'd2);
    send_reading(16'd2000, STATUS_OK);
    send_reading(16'd65535, 8'hFF);
    send_reading(16'd1999, STATUS_SIGMA);
    send_byte(CHAR_F);
    send_reading(16'd21, STATUS_OK);
    send_frame(CHAR_0 + 8'd5, CHAR_0 + 8'd5, 8'h00);
    send_reading(16'd20, STATUS_OK);
    send_reading(16'd500, STATUS_OK);

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      send_gap_pct = (phase_no < 2) ? 15 : (phase_no < 4) ? 48 : 0;
      recv_gap_pct = (phase_no < 2) ? 48 : (phase_no < 4) ? 15 : 0;
      case (phase_no)
        0: write_brake(11'd2047);
        1: write_brake(11'd0);
        2: write_brake(11'd2000);
        3: write_brake(11'd21);
        4: write_brake(11'd1000);
        default: write_brake(11'($urandom_range(0, 2047)));
      endcase
      random_traffic(215);
    end

    wait_until_drained();
    $display({"Checked %0d results from %0d command bytes and %0d range readings",
              " over %0d brake settings."},
             sb.checked, sb.bytes_seen, sb.readings_seen, settings_used);
    $display("Saw %0d motor commands, %0d refused forward frames and %0d obstacle events.",
             sb.commands_seen, sb.refusals_seen, sb.events_seen);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("Mismatches: %0d, results outstanding: %0d.", sb.mismatches,
               sb.expected_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mcp_pkg.sv
src/mcp_core.sv
src/motor_command_parser_with_obstacle_lock.sv
src/mcp_checker.sv
test/tb_motor_command_parser_with_obstacle_lock.sv
